[hdl/dirty_rectangle_tracker_macros.svh]
// Assertion macros shared by the checker file.
`ifndef DIRTY_RECTANGLE_TRACKER_MACROS_SVH
`define DIRTY_RECTANGLE_TRACKER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define DRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define DRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/drt_pkg.sv]
`timescale 1ns / 1ps
package drt_pkg;

    // Request codes
    typedef enum logic [1:0] {
        OP_MARK  = 2'd0,
        OP_ALL   = 2'd1,
        OP_FRAME = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // Input item
    typedef struct packed {
        t_op                opcode;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
        logic        [4:0]  read_index;
    } t_item;

    // Result item
    typedef struct packed {
        logic        full_screen;
        logic [5:0]  entry_count;
        logic        read_ok;
        logic [14:0] out_x;
        logic [14:0] out_y;
        logic [16:0] out_w;
        logic [16:0] out_h;
    } t_result;

    // Classified request, front to back. r and b are the clipped right/bottom edges.
    typedef struct packed {
        t_op         op;
        logic        skip;
        logic [14:0] x;
        logic [14:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [16:0] r;
        logic [16:0] b;
        logic [4:0]  idx;
    } t_cmd;

    // One stored region
    typedef struct packed {
        logic [14:0] left;
        logic [14:0] top;
        logic [16:0] width;
        logic [16:0] height;
    } t_entry;

endpackage

[hdl/dirty_rectangle_tracker.sv]
`timescale 1ns / 1ps
// Channel   Direction  Signals
// in        input      i_in_valid, o_in_ready, i_item (drt_pkg::t_item)
// out       output     o_out_valid, i_out_ready, o_result (drt_pkg::t_result)
// cfg       input      i_cfg_wr_en, i_cfg_index, i_cfg_data
//
// Mark all, new frame, rejected marks and failed reads: the result is registered from the idle state.
// A good read passes through the read-data state. A mark into a non-empty list scans it one entry per cycle
// through the region memory read port, up to the first entry it touches or the last stored entry.
// A two-entry queue takes up to two items while the back end scans or the result is held.
// Reset: synchronous, active low; list empty, whole-screen mode set, screen size 0.
module dirty_rectangle_tracker #(
    parameter int MAX_REGIONS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  drt_pkg::t_item   i_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output drt_pkg::t_result o_result,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_index,
    input  logic [14:0]      i_cfg_data
);
    import drt_pkg::*;

    localparam logic CFG_SCREEN_W = 1'b0;
    localparam logic CFG_SCREEN_H = 1'b1;

    logic [14:0] r_screen_w, r_screen_h;
    t_cmd        front_cmd, q_cmd;
    logic        q_vld, q_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= '0;
            r_screen_h <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SCREEN_W: r_screen_w <= i_cfg_data;
                CFG_SCREEN_H: r_screen_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    drt_front u_front (
        .i_item     (i_item),
        .i_screen_w (r_screen_w),
        .i_screen_h (r_screen_h),
        .o_cmd      (front_cmd)
    );

    drt_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_vld  (i_in_valid),
        .o_wr_rdy  (o_in_ready),
        .i_wr_data (front_cmd),
        .o_rd_vld  (q_vld),
        .i_rd_pop  (q_pop),
        .o_rd_data (q_cmd)
    );

    drt_back #(.MAX_REGIONS(MAX_REGIONS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_vld   (q_vld),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

endmodule

[hdl/drt_front.sv]
`timescale 1ns / 1ps
module drt_front (
    input  drt_pkg::t_item i_item,
    input  logic [14:0]    i_screen_w,
    input  logic [14:0]    i_screen_h,
    output drt_pkg::t_cmd  o_cmd
);
    import drt_pkg::*;

    logic signed [17:0] xs, ys, ws, hs;
    logic signed [17:0] x1, y1, w1, h1, w2, h2;
    logic signed [17:0] sw, sh, re, be;

    // Clip against the left/top edges, then the right/bottom edges
    always_comb begin
        xs = {{2{i_item.rect_x[15]}}, i_item.rect_x};
        ys = {{2{i_item.rect_y[15]}}, i_item.rect_y};
        ws = {{2{i_item.rect_w[15]}}, i_item.rect_w};
        hs = {{2{i_item.rect_h[15]}}, i_item.rect_h};
        sw = {3'b000, i_screen_w};
        sh = {3'b000, i_screen_h};

        x1 = (xs < 0) ? 18'sd0 : xs;
        w1 = (xs < 0) ? ws + xs : ws;
        y1 = (ys < 0) ? 18'sd0 : ys;
        h1 = (ys < 0) ? hs + ys : hs;

        w2 = ((i_screen_w != 15'd0) && (x1 + w1 > sw)) ? sw - x1 : w1;
        h2 = ((i_screen_h != 15'd0) && (y1 + h1 > sh)) ? sh - y1 : h1;
        re = x1 + w2;
        be = y1 + h2;

        o_cmd.op   = i_item.opcode;
        o_cmd.skip = (ws <= 0) || (hs <= 0) || (w2 <= 0) || (h2 <= 0);
        o_cmd.x    = x1[14:0];
        o_cmd.y    = y1[14:0];
        o_cmd.w    = w2[15:0];
        o_cmd.h    = h2[15:0];
        o_cmd.r    = re[16:0];
        o_cmd.b    = be[16:0];
        o_cmd.idx  = i_item.read_index;
    end

endmodule

[hdl/drt_fifo.sv]
`timescale 1ns / 1ps
module drt_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_vld,
    output logic          o_wr_rdy,
    input  drt_pkg::t_cmd i_wr_data,
    output logic          o_rd_vld,
    input  logic          i_rd_pop,
    output drt_pkg::t_cmd o_rd_data
);
    import drt_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_wr_rdy  = (r_cnt != 2'd2);
    assign o_rd_vld  = (r_cnt != 2'd0);
    assign o_rd_data = r_mem[r_rp];
    assign push      = i_wr_vld && o_wr_rdy;
    assign pop       = i_rd_pop && o_rd_vld;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // Payload storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_wr_data;
    end

endmodule

[hdl/drt_back.sv]
`timescale 1ns / 1ps
module drt_back #(
    parameter int MAX_REGIONS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_vld,
    input  drt_pkg::t_cmd   i_cmd,
    output logic            o_cmd_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output drt_pkg::t_result o_result
);
    import drt_pkg::*;

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int AW = (IW > 5) ? IW : 5;
    localparam int KW = AW + CW;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RDATA} t_state;

    t_entry          r_mem [MAX_REGIONS];
    t_entry          r_rd_data;
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_whole, n_whole;
    logic [CW-1:0]   r_scan, n_scan;
    logic            r_rd_vld;
    logic [IW-1:0]   r_rd_idx;
    t_cmd            r_cmd, n_cmd;
    t_result         r_out, n_out;
    logic            r_out_vld, n_out_vld;

    logic            start, issue, touch, last, idx_ok, done;
    logic [AW-1:0]   idx_ext;
    logic [IW-1:0]   rd_addr;
    logic            we;
    logic [IW-1:0]   waddr;
    t_entry          wdata;
    logic [16:0]     ar, ab, mx1, my1;
    logic [14:0]     mx0, my0;
    t_entry          merged, fresh_q, fresh_i;
    t_result         res_zero;

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

    // Hit test of the request against the entry coming out of memory
    always_comb begin
        ar    = {2'b00, r_rd_data.left} + r_rd_data.width;
        ab    = {2'b00, r_rd_data.top} + r_rd_data.height;
        touch = !(({2'b00, r_rd_data.left} > r_cmd.r) || ({2'b00, r_cmd.x} > ar) ||
                  ({2'b00, r_rd_data.top} > r_cmd.b) ||
                  ({2'b00, r_cmd.y} > ab));
        mx0   = (r_rd_data.left < r_cmd.x) ? r_rd_data.left : r_cmd.x;
        my0   = (r_rd_data.top < r_cmd.y) ? r_rd_data.top : r_cmd.y;
        mx1   = (ar > r_cmd.r) ? ar : r_cmd.r;
        my1   = (ab > r_cmd.b) ? ab : r_cmd.b;
        merged.left   = mx0;
        merged.top    = my0;
        merged.width  = mx1 - {2'b00, mx0};
        merged.height = my1 - {2'b00, my0};
        fresh_q = '{left: r_cmd.x, top: r_cmd.y,
                    width: {1'b0, r_cmd.w}, height: {1'b0, r_cmd.h}};
        fresh_i = '{left: i_cmd.x, top: i_cmd.y,
                    width: {1'b0, i_cmd.w}, height: {1'b0, i_cmd.h}};
        last    = ({{(CW > IW ? CW - IW : 0){1'b0}}, r_rd_idx} == KW'(r_count) - KW'(1));
    end

    // Read port addressing and scan issue
    always_comb begin
        idx_ext = AW'(i_cmd.idx);
        idx_ok  = !r_whole && (KW'(idx_ext) < KW'(r_count));
        start   = (r_state == S_IDLE) && i_cmd_vld && !r_out_vld;
        done    = (r_state == S_SCAN) && r_rd_vld && (touch || last);
        issue   = (r_state == S_SCAN) && (r_scan < r_count) && !done;
        rd_addr = (r_state == S_IDLE) ? idx_ext[IW-1:0] : r_scan[IW-1:0];
    end

    // Control: next state, counters, memory write, result
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_whole   = r_whole;
        n_scan    = r_scan;
        n_cmd     = r_cmd;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        we        = 1'b0;
        waddr     = r_rd_idx;
        wdata     = merged;
        res_zero  = '0;
        o_cmd_pop = start;

        if (r_out_vld && i_out_ready) n_out_vld = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd;
                    unique case (i_cmd.op)
                        OP_MARK: begin
                            if (!i_cmd.skip && !r_whole) begin
                                if (r_count == '0) begin
                                    we      = 1'b1;
                                    waddr   = '0;
                                    wdata   = fresh_i;
                                    n_count = CW'(1);
                                end else begin
                                    n_scan  = '0;
                                    n_state = S_SCAN;
                                end
                            end
                        end
                        OP_ALL: begin
                            n_whole = 1'b1;
                            n_count = '0;
                        end
                        OP_FRAME: begin
                            n_whole = 1'b0;
                            n_count = '0;
                        end
                        OP_READ: begin
                            if (idx_ok) n_state = S_RDATA;
                        end
                        default: ;
                    endcase
                    if (n_state == S_IDLE) begin
                        n_out_vld = 1'b1;
                        n_out     = res_zero;
                        n_out.full_screen = n_whole;
                        n_out.entry_count = n_whole ? 6'd0 : 6'(n_count);
                    end
                end
            end
            S_SCAN: begin
                if (issue) n_scan = r_scan + CW'(1);
                if (done) begin
                    if (touch) begin
                        we    = 1'b1;
                        waddr = r_rd_idx;
                        wdata = merged;
                    end else if (KW'(r_count) >= KW'(MAX_REGIONS)) begin
                        n_whole = 1'b1;
                        n_count = '0;
                    end else begin
                        we      = 1'b1;
                        waddr   = r_count[IW-1:0];
                        wdata   = fresh_q;
                        n_count = r_count + CW'(1);
                    end
                    n_state   = S_IDLE;
                    n_out_vld = 1'b1;
                    n_out     = res_zero;
                    n_out.full_screen = n_whole;
                    n_out.entry_count = n_whole ? 6'd0 : 6'(n_count);
                end
            end
            S_RDATA: begin
                n_state   = S_IDLE;
                n_out_vld = 1'b1;
                n_out.full_screen = r_whole;
                n_out.entry_count = 6'(r_count);
                n_out.read_ok     = 1'b1;
                n_out.out_x       = r_rd_data.left;
                n_out.out_y       = r_rd_data.top;
                n_out.out_w       = r_rd_data.width;
                n_out.out_h       = r_rd_data.height;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_whole   <= 1'b1;
            r_scan    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_whole   <= n_whole;
            r_scan    <= n_scan;
            r_rd_vld  <= issue;
            r_out_vld <= n_out_vld;
        end
        r_cmd    <= n_cmd;
        r_out    <= n_out;
        r_rd_idx <= r_scan[IW-1:0];
    end

    // Region memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rd_data <= r_mem[rd_addr];
    end

endmodule

[hdl/drt_checker.sv]
`timescale 1ns / 1ps
`include "dirty_rectangle_tracker_macros.svh"
module drt_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input drt_pkg::t_result o_result
);
    import drt_pkg::*;

    // Whole-screen mode never reports stored entries
    `DRT_ASSERT_NOW(a_full_no_count, o_out_valid && o_result.full_screen, o_result.entry_count == 6'd0, "count in full-screen mode")
    // A read cannot succeed in whole-screen mode
    `DRT_ASSERT_NOW(a_read_not_full, o_out_valid && o_result.read_ok, !o_result.full_screen, "read ok in full-screen mode")
    // Failed or absent reads carry zero data
    `DRT_ASSERT_NOW(a_zero_data, o_out_valid && !o_result.read_ok, o_result.out_x == 15'd0 && o_result.out_y == 15'd0 && o_result.out_w == 17'd0 && o_result.out_h == 17'd0, "nonzero data without read")
    // A stalled result holds
    `DRT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_result), "result dropped under stall")

endmodule

bind dirty_rectangle_tracker drt_checker u_drt_checker (.*);

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import drt_pkg::*;

    localparam int MAX_REGIONS = 32;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 1800;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_in_valid;
    logic    o_in_ready;
    t_item   i_item;
    logic    o_out_valid;
    logic    i_out_ready;
    t_result o_result;
    logic    i_cfg_wr_en;
    logic    i_cfg_index;
    logic [14:0] i_cfg_data;

    // Predictor copy of the region list and settings
    int      pred_left[MAX_REGIONS];
    int      pred_top[MAX_REGIONS];
    int      pred_width[MAX_REGIONS];
    int      pred_height[MAX_REGIONS];
    int      pred_count;
    bit      pred_full;
    int      pred_scr_w;
    int      pred_scr_h;

    t_result pending_results[$];
    int      mismatch_count;
    int      items_sent;
    int      results_seen;
    int      cycle_count;
    bit      quiet_mode;
    int      ready_hold;

    dirty_rectangle_tracker #(.MAX_REGIONS(MAX_REGIONS)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_item      (i_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Clip and merge a mark into the predicted list
    function automatic void apply_mark(int x, int y, int w, int h);
        int ar, ab, br, bb, x0, y0, x1, y1;
        if (pred_full) return;
        if (w <= 0 || h <= 0) return;
        if (x < 0) begin
            w += x;
            x = 0;
        end
        if (y < 0) begin
            h += y;
            y = 0;
        end
        if (pred_scr_w > 0 && x + w > pred_scr_w) w = pred_scr_w - x;
        if (pred_scr_h > 0 && y + h > pred_scr_h) h = pred_scr_h - y;
        if (w <= 0 || h <= 0) return;
        br = x + w;
        bb = y + h;
        for (int i = 0; i < pred_count; i++) begin
            ar = pred_left[i] + pred_width[i];
            ab = pred_top[i] + pred_height[i];
            if (!(pred_left[i] > br || x > ar || pred_top[i] > bb || y > ab)) begin
                x0 = pred_left[i] < x ? pred_left[i] : x;
                y0 = pred_top[i] < y ? pred_top[i] : y;
                x1 = ar > br ? ar : br;
                y1 = ab > bb ? ab : bb;
                pred_left[i] = x0;
                pred_top[i] = y0;
                pred_width[i] = x1 - x0;
                pred_height[i] = y1 - y0;
                return;
            end
        end
        if (pred_count >= MAX_REGIONS) begin
            pred_full = 1'b1;
            pred_count = 0;
            return;
        end
        pred_left[pred_count] = x;
        pred_top[pred_count] = y;
        pred_width[pred_count] = w;
        pred_height[pred_count] = h;
        pred_count++;
    endfunction

    // Expected result of one request; updates the predicted list
    function automatic t_result predict_tracker_result(t_item it);
        t_result res;
        int      idx;
        res = '0;
        case (it.opcode)
            OP_MARK: apply_mark(int'(it.rect_x), int'(it.rect_y),
                                int'(it.rect_w), int'(it.rect_h));
            OP_ALL: begin
                pred_full = 1'b1;
                pred_count = 0;
            end
            OP_FRAME: begin
                pred_full = 1'b0;
                pred_count = 0;
            end
            default: begin
                idx = it.read_index;
                if (!pred_full && idx < pred_count) begin
                    res.read_ok = 1'b1;
                    res.out_x = pred_left[idx][14:0];
                    res.out_y = pred_top[idx][14:0];
                    res.out_w = pred_width[idx][16:0];
                    res.out_h = pred_height[idx][16:0];
                end
            end
        endcase
        res.full_screen = pred_full;
        res.entry_count = pred_full ? 6'd0 : pred_count[5:0];
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] result %0d: %s is %0d, expected %0d",
                 $realtime, results_seen, field, got, want);
        mismatch_count++;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, full_screen", o_result.full_screen, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_result.full_screen !== want.full_screen)
                    report_mismatch("full_screen", o_result.full_screen, want.full_screen);
                if (o_result.entry_count !== want.entry_count)
                    report_mismatch("entry_count", o_result.entry_count, want.entry_count);
                if (o_result.read_ok !== want.read_ok)
                    report_mismatch("read_ok", o_result.read_ok, want.read_ok);
                if (o_result.out_x !== want.out_x)
                    report_mismatch("out_x", o_result.out_x, want.out_x);
                if (o_result.out_y !== want.out_y)
                    report_mismatch("out_y", o_result.out_y, want.out_y);
                if (o_result.out_w !== want.out_w)
                    report_mismatch("out_w", o_result.out_w, want.out_w);
                if (o_result.out_h !== want.out_h)
                    report_mismatch("out_h", o_result.out_h, want.out_h);
            end
            results_seen++;
        end
    end

    // Output stall bursts
    initial begin
        i_out_ready = 1'b0;
        ready_hold = 0;
        forever begin
            @(negedge i_clk);
            if (ready_hold > 0 && !quiet_mode) begin
                i_out_ready = 1'b0;
                ready_hold--;
            end else begin
                i_out_ready = 1'b1;
                ready_hold = 0;
                if (!quiet_mode && $urandom_range(0, 7) == 0)
                    ready_hold = $urandom_range(1, 11);
            end
        end
    end

    // One request transfer; entered and left at a falling edge
    task automatic send_request(t_item it);
        if (!quiet_mode && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        i_item = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_tracker_result(it));
        items_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_op(t_op op, int x = 0, int y = 0, int w = 0, int h = 0,
                           int idx = 0);
        t_item it;
        it.opcode = op;
        it.rect_x = x[15:0];
        it.rect_y = y[15:0];
        it.rect_w = w[15:0];
        it.rect_h = h[15:0];
        it.read_index = idx[4:0];
        send_request(it);
    endtask

    // Register write, only once all results are back
    task automatic write_screen_size(int width, int height);
        wait (pending_results.size() == 0);
        repeat (40) @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = 1'b0;
        i_cfg_data = width[14:0];
        @(negedge i_clk);
        i_cfg_index = 1'b1;
        i_cfg_data = height[14:0];
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        pred_scr_w = width & 32'h7fff;
        pred_scr_h = height & 32'h7fff;
    endtask

    task automatic test_reset_state;
        send_op(OP_READ, 0, 0, 0, 0, 0);
        send_op(OP_MARK, 10, 10, 5, 5);
        send_op(OP_FRAME);
        send_op(OP_READ, 0, 0, 0, 0, 31);
    endtask

    task automatic test_clipping_and_merge;
        write_screen_size(32767, 32767);
        send_op(OP_MARK, -5, -7, 10, 10);       // left and top clip
        send_op(OP_MARK, 10, 0, 5, 3);          // clear of the first region
        send_op(OP_MARK, 100, 100, 0, 5);       // empty width
        send_op(OP_MARK, 100, 100, 5, -1);      // empty height
        send_op(OP_MARK, -20, 5, 10, 10);       // empty after clipping
        send_op(OP_MARK, 32760, 32760, 32767, 32767); // right and bottom clip
        send_op(OP_READ, 0, 0, 0, 0, 0);
        send_op(OP_READ, 0, 0, 0, 0, 1);
        send_op(OP_READ, 0, 0, 0, 0, 2);
        send_op(OP_ALL);
        send_op(OP_READ, 0, 0, 0, 0, 0);
        write_screen_size(0, 0);
        send_op(OP_FRAME);
        send_op(OP_MARK, 32767, 32767, 32767, 32767); // no clipping at size zero
        send_op(OP_MARK, -32768, -32768, -32768, -32768);
        send_op(OP_READ, 0, 0, 0, 0, 0);
        send_op(OP_READ, 0, 0, 0, 0, 1);
    endtask

    // Disjoint one-pixel marks overflow the list into whole-screen mode
    task automatic test_list_overflow;
        write_screen_size(200, 200);
        send_op(OP_FRAME);
        for (int k = 0; k <= MAX_REGIONS; k++) begin
            send_op(OP_MARK, 3 * (k % 16), 3 * (k / 16), 1, 1);
            if (k == MAX_REGIONS - 1) send_op(OP_READ, 0, 0, 0, 0, 31);
        end
        send_op(OP_READ, 0, 0, 0, 0, 0);
    endtask

    // Random mark: mostly on-screen and small, some grid, some noise
    task automatic send_random_mark(int k);
        int span_w, span_h, pick;
        span_w = pred_scr_w > 0 ? pred_scr_w : 400;
        span_h = pred_scr_h > 0 ? pred_scr_h : 400;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            send_op(OP_MARK, int'($urandom_range(0, span_w + 16)) - 8,
                    int'($urandom_range(0, span_h + 16)) - 8,
                    $urandom_range(1, 40) - 2, $urandom_range(1, 40) - 2);
        else if (pick < 8)
            send_op(OP_MARK, 3 * (k % 16), 3 * (k / 16) % 60, 1, 1);
        else
            send_op(OP_MARK, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic test_random_frames;
        int runs, pick;
        runs = 0;
        while (items_sent < RANDOM_ITEMS + 60) begin
            if (items_sent > RANDOM_ITEMS - 150) quiet_mode = 1'b1;
            if (runs % 6 == 0) begin
                pick = $urandom_range(0, 4);
                case (pick)
                    0: write_screen_size(0, 0);
                    1: write_screen_size(32767, 32767);
                    2: write_screen_size(64, 48);
                    3: write_screen_size(0, $urandom_range(1, 32767));
                    default: write_screen_size($urandom_range(1, 32767), $urandom);
                endcase
            end
            runs++;
            send_op($urandom_range(0, 7) == 0 ? OP_ALL : OP_FRAME);
            for (int k = 0; k < $urandom_range(1, 45); k++) begin
                pick = $urandom_range(0, 19);
                if (pick < 13)
                    send_random_mark(k);
                else if (pick < 18)
                    send_op(OP_READ, 0, 0, 0, 0,
                            pred_count > 0 && pick < 16 ?
                            $urandom_range(0, pred_count - 1) : $urandom_range(0, 31));
                else if (pick == 18)
                    send_op(OP_ALL);
                else
                    send_op(t_op'($urandom_range(0, 3)), $urandom, $urandom,
                            $urandom, $urandom, $urandom);
            end
            for (int j = 0; j < pred_count && j < 4; j++)
                send_op(OP_READ, 0, 0, 0, 0, $urandom_range(0, pred_count - 1));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_item = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        mismatch_count = 0;
        items_sent = 0;
        results_seen = 0;
        cycle_count = 0;
        quiet_mode = 1'b0;
        pred_count = 0;
        pred_full = 1'b1;
        pred_scr_w = 0;
        pred_scr_h = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_clipping_and_merge();
        test_list_overflow();
        test_random_frames();

        wait (pending_results.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("Sent %0d requests and checked %0d results over several screen sizes,",
                 items_sent, results_seen);
        $display("including clipping, merges, list overflow and reads.");
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
